/* rtl/c8ic_pkg.sv */
package c8ic_pkg;

    localparam int MEM_BYTES          = 4096;
    localparam int DEF_SCREEN_WIDTH   = 64;
    localparam int DEF_SCREEN_HEIGHT  = 32;
    localparam int DEF_STACK_DEPTH    = 32;
    localparam logic [11:0] PC_START  = 12'h200;
    localparam logic [15:0] FONT_STRIDE = 16'd5;

    typedef enum logic [1:0] {
        OPER_WRITE = 2'd0,
        OPER_STEP  = 2'd1,
        OPER_READ  = 2'd2,
        OPER_NONE  = 2'd3
    } t_oper;

    // opcode groups (top nibble)
    localparam logic [3:0] G_SYS   = 4'h0;
    localparam logic [3:0] G_JP    = 4'h1;
    localparam logic [3:0] G_CALL  = 4'h2;
    localparam logic [3:0] G_SE_I  = 4'h3;
    localparam logic [3:0] G_SNE_I = 4'h4;
    localparam logic [3:0] G_SE_R  = 4'h5;
    localparam logic [3:0] G_LD_I  = 4'h6;
    localparam logic [3:0] G_ADD_I = 4'h7;
    localparam logic [3:0] G_ALU   = 4'h8;
    localparam logic [3:0] G_SNE_R = 4'h9;
    localparam logic [3:0] G_LDI   = 4'hA;
    localparam logic [3:0] G_JPV0  = 4'hB;
    localparam logic [3:0] G_RND   = 4'hC;
    localparam logic [3:0] G_DRW   = 4'hD;
    localparam logic [3:0] G_KEY   = 4'hE;
    localparam logic [3:0] G_MISC  = 4'hF;

    localparam logic [7:0] OP_CLS   = 8'hE0;
    localparam logic [7:0] OP_RET   = 8'hEE;
    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [3:0] A_MOV  = 4'h0;
    localparam logic [3:0] A_OR   = 4'h1;
    localparam logic [3:0] A_AND  = 4'h2;
    localparam logic [3:0] A_XOR  = 4'h3;
    localparam logic [3:0] A_ADD  = 4'h4;
    localparam logic [3:0] A_SUB  = 4'h5;
    localparam logic [3:0] A_SHR  = 4'h6;
    localparam logic [3:0] A_SUBN = 4'h7;
    localparam logic [3:0] A_SHL  = 4'hE;

    localparam logic [7:0] F_GET_DT = 8'h07;
    localparam logic [7:0] F_SET_DT = 8'h15;
    localparam logic [7:0] F_SET_ST = 8'h18;
    localparam logic [7:0] F_ADD_I  = 8'h1E;
    localparam logic [7:0] F_FONT   = 8'h29;
    localparam logic [7:0] F_BCD    = 8'h33;
    localparam logic [7:0] F_STORE  = 8'h55;
    localparam logic [7:0] F_LOAD   = 8'h65;

    localparam logic [3:0] REG_F = 4'hF;

    typedef enum logic [2:0] {
        K_SIMPLE,
        K_BCD,
        K_STORE,
        K_LOAD,
        K_DRAW
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  wr_x;
        logic  wr_f;
        logic  illegal;
        logic  changed;
    } t_dec;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_FETCH_HI,
        DP_FETCH_LO,
        DP_READ_X,
        DP_READ_Y,
        DP_READ_0,
        DP_EXEC,
        DP_WB_F,
        DP_WB_X,
        DP_BCD,
        DP_ST_RD,
        DP_ST_WR,
        DP_LD_RD,
        DP_LD_WR,
        DP_DMOD,
        DP_DR_RD,
        DP_DR_WR,
        DP_DR_FLAG,
        DP_TICK
    } t_dp_cmd;

    typedef struct packed {
        logic [15:0] op;
        logic [3:0]  k;
        logic        mod_done;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FETCH_HI,
        S_FETCH_LO,
        S_READ_X,
        S_READ_Y,
        S_READ_0,
        S_EXEC,
        S_WB_F,
        S_WB_X,
        S_BCD,
        S_ST_RD,
        S_ST_WR,
        S_LD_RD,
        S_LD_WR,
        S_DMOD,
        S_DR_RD,
        S_DR_WR,
        S_DR_FLAG,
        S_TICK,
        S_RESP
    } t_state;

    function automatic t_dec decode(input logic [15:0] op);
        t_dec d;
        d = '{kind: K_SIMPLE, wr_x: 1'b0, wr_f: 1'b0, illegal: 1'b0, changed: 1'b0};
        case (op[15:12])
            G_SYS: begin
                if (op[7:0] == OP_CLS) d.changed = 1'b1;
                else if (op[7:0] != OP_RET) d.illegal = 1'b1;
            end
            G_LD_I, G_ADD_I, G_RND: d.wr_x = 1'b1;
            G_ALU: begin
                case (op[3:0])
                    A_MOV, A_OR, A_AND, A_XOR: d.wr_x = 1'b1;
                    A_ADD, A_SUB, A_SHR, A_SUBN, A_SHL: begin
                        d.wr_x = 1'b1;
                        d.wr_f = 1'b1;
                    end
                    default: d.illegal = 1'b1;
                endcase
            end
            G_DRW: begin
                d.kind    = K_DRAW;
                d.changed = 1'b1;
            end
            G_KEY: begin
                if (op[7:0] != KEY_DOWN && op[7:0] != KEY_UP) d.illegal = 1'b1;
            end
            G_MISC: begin
                case (op[7:0])
                    F_GET_DT: d.wr_x = 1'b1;
                    F_SET_DT, F_SET_ST, F_ADD_I, F_FONT: ;
                    F_BCD:   d.kind = K_BCD;
                    F_STORE: d.kind = K_STORE;
                    F_LOAD:  d.kind = K_LOAD;
                    default: d.illegal = 1'b1;
                endcase
            end
            default: ;
        endcase
        return d;
    endfunction

    // decimal digit idx (0 hundreds, 1 tens, 2 ones); reciprocal multiply,
    // exact over 0..255
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] idx);
        logic [15:0] hp;
        logic [15:0] qp;
        logic [7:0]  hun;
        logic [7:0]  q10;
        logic [7:0]  dig;
        hp  = 16'(v) * 16'd41;
        qp  = 16'(v) * 16'd205;
        hun = {4'd0, hp[15:12]};
        q10 = {3'd0, qp[15:11]};
        unique case (idx)
            2'd0:    dig = hun;
            2'd1:    dig = q10 - 8'(hun * 8'd10);
            default: dig = v - 8'(q10 * 8'd10);
        endcase
        return dig;
    endfunction

endpackage

/* rtl/c8ic_dp.sv */
module c8ic_dp
    import c8ic_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int STACK_DEPTH   = DEF_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_mem_address,
    input  logic [7:0]  i_mem_data,
    input  logic [15:0] i_keys,
    input  logic [7:0]  i_random_byte,
    input  logic [4:0]  i_row_select,
    output t_dp_stat    o_stat,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_opcode_done,
    output logic        o_bad_opcode,
    output logic        o_display_changed,
    output logic        o_sound_on,
    output logic [7:0]  o_delay_value,
    output logic [63:0] o_row_pixels
);

    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int SW = $clog2(STACK_DEPTH);

    logic [7:0]              r_mem [MEM_BYTES];
    logic [7:0]              r_mem_q;
    logic [SCREEN_WIDTH-1:0] r_screen [SCREEN_HEIGHT];
    logic [7:0]              r_v [16];
    logic [7:0]              r_vq;
    logic [11:0]             r_stack [STACK_DEPTH];

    logic [15:0]   r_i;
    logic [11:0]   r_pc;
    logic [SW-1:0] r_sp;
    logic [7:0]    r_delay;
    logic [7:0]    r_sound;
    logic [15:0]   r_op;
    logic [7:0]    r_vx;
    logic [7:0]    r_vy;
    logic [7:0]    r_res;
    logic          r_flag;
    logic [3:0]    r_k;
    logic [7:0]    r_xm;
    logic [7:0]    r_ym;
    logic          r_hit;
    logic [15:0]   r_keys;
    logic [7:0]    r_rnd;
    logic [15:0]   r_opcode_done;
    logic          r_illegal;
    logic          r_changed;
    logic [63:0]   r_pixels;

    logic [15:0]   n_i;
    logic [11:0]   n_pc;
    logic [SW-1:0] n_sp;
    logic [7:0]    n_delay;
    logic [7:0]    n_sound;
    logic [7:0]    n_res;
    logic          n_flag;
    logic          n_push;
    logic          n_clear;

    logic [11:0]   addr_ik;
    logic [11:0]   mem_raddr;
    logic [11:0]   mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_we;
    logic [3:0]    v_raddr;
    logic [3:0]    v_waddr;
    logic [7:0]    v_wdata;
    logic          v_we;
    logic [YW-1:0] scr_raddr;
    logic [SCREEN_WIDTH-1:0] scr_rdata;
    logic [SCREEN_WIDTH-1:0] mask;
    logic [7:0]    pos;
    logic [SW-1:0] sp_inc;
    logic [SW-1:0] sp_dec;
    logic [8:0]    sum9;
    logic          key_hit;
    logic          row_ok;
    logic [63:0]   row_ext;
    t_dec          dec;

    assign dec     = decode(r_op);
    assign addr_ik = 12'(r_i + 16'(r_k));
    assign sp_inc  = (r_sp == SW'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec  = (r_sp == '0) ? SW'(STACK_DEPTH - 1) : r_sp - 1'b1;
    assign row_ok  = int'(i_row_select) < SCREEN_HEIGHT;

    // main memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_ik;
        mem_wdata = r_vq;
        unique case (i_cmd)
            DP_FETCH_HI:        mem_raddr = r_pc;
            DP_FETCH_LO:        mem_raddr = r_pc + 12'd1;
            DP_LD_RD, DP_DR_RD: mem_raddr = addr_ik;
            default:            mem_raddr = r_pc;
        endcase
        if (i_cmd == DP_ACCEPT && i_operation == OPER_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = i_mem_address;
            mem_wdata = i_mem_data;
        end else if (i_cmd == DP_BCD) begin
            mem_we    = 1'b1;
            mem_wdata = bcd_digit(r_vx, r_k[1:0]);
        end else if (i_cmd == DP_ST_WR) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_mem_q <= r_mem[mem_raddr];
    end

    // register file ports
    always_comb begin
        unique case (i_cmd)
            DP_READ_X: v_raddr = r_op[11:8];
            DP_READ_Y: v_raddr = r_op[7:4];
            DP_ST_RD:  v_raddr = r_k;
            default:   v_raddr = 4'h0;
        endcase
        v_we    = 1'b1;
        v_waddr = REG_F;
        v_wdata = {7'b0, r_flag};
        unique case (i_cmd)
            DP_WB_F: ;
            DP_WB_X: begin
                v_waddr = r_op[11:8];
                v_wdata = r_res;
            end
            DP_LD_WR: begin
                v_waddr = r_k;
                v_wdata = r_mem_q;
            end
            DP_DR_FLAG: v_wdata = {7'b0, r_hit};
            default: v_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 16; j++) r_v[j] <= 8'd0;
        end else if (v_we) begin
            r_v[v_waddr] <= v_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vq <= r_v[v_raddr];
    end

    // display: one read port, shared by row reads and sprite rows
    assign scr_raddr = (i_cmd == DP_ACCEPT) ? i_row_select[YW-1:0] : r_ym[YW-1:0];
    assign scr_rdata = r_screen[scr_raddr];

    always_comb begin
        row_ext = '0;
        row_ext[SCREEN_WIDTH-1:0] = scr_rdata;
    end

    always_comb begin
        mask = '0;
        pos  = '0;
        for (int c = 0; c < 8; c++) begin
            pos = r_xm + 8'(c);
            if (pos >= 8'(SCREEN_WIDTH)) pos = pos - 8'(SCREEN_WIDTH);
            if (r_mem_q[7-c]) mask[pos[XW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SCREEN_HEIGHT; j++) r_screen[j] <= '0;
        end else if (n_clear) begin
            for (int j = 0; j < SCREEN_HEIGHT; j++) r_screen[j] <= '0;
        end else if (i_cmd == DP_DR_WR) begin
            r_screen[r_ym[YW-1:0]] <= scr_rdata ^ mask;
        end
    end

    // combinational execute, registered on DP_EXEC
    always_comb begin
        n_i     = r_i;
        n_pc    = r_pc;
        n_sp    = r_sp;
        n_delay = r_delay;
        n_sound = r_sound;
        n_res   = 8'd0;
        n_flag  = 1'b0;
        n_push  = 1'b0;
        n_clear = 1'b0;
        sum9    = {1'b0, r_vx} + {1'b0, r_vy};
        key_hit = (r_vx < 8'd16) ? r_keys[r_vx[3:0]] : 1'b0;
        if (i_cmd == DP_EXEC) begin
            unique case (r_op[15:12])
                G_SYS: begin
                    if (r_op[7:0] == OP_CLS) begin
                        n_clear = 1'b1;
                    end else if (r_op[7:0] == OP_RET) begin
                        n_pc = r_stack[r_sp];
                        n_sp = sp_dec;
                    end
                end
                G_JP: n_pc = r_op[11:0];
                G_CALL: begin
                    n_push = 1'b1;
                    n_sp   = sp_inc;
                    n_pc   = r_op[11:0];
                end
                G_SE_I:  if (r_vx == r_op[7:0]) n_pc = r_pc + 12'd2;
                G_SNE_I: if (r_vx != r_op[7:0]) n_pc = r_pc + 12'd2;
                G_SE_R:  if (r_vx == r_vy) n_pc = r_pc + 12'd2;
                G_LD_I:  n_res = r_op[7:0];
                G_ADD_I: n_res = r_vx + r_op[7:0];
                G_ALU: begin
                    case (r_op[3:0])
                        A_MOV: n_res = r_vy;
                        A_OR:  n_res = r_vx | r_vy;
                        A_AND: n_res = r_vx & r_vy;
                        A_XOR: n_res = r_vx ^ r_vy;
                        A_ADD: begin
                            n_res  = sum9[7:0];
                            n_flag = sum9[8];
                        end
                        A_SUB: begin
                            n_res  = r_vx - r_vy;
                            n_flag = r_vx > r_vy;
                        end
                        A_SHR: begin
                            n_res  = {1'b0, r_vx[7:1]};
                            n_flag = r_vx[0];
                        end
                        A_SUBN: begin
                            n_res  = r_vy - r_vx;
                            n_flag = r_vx <= r_vy;
                        end
                        A_SHL: begin
                            n_res  = {r_vx[6:0], 1'b0};
                            n_flag = r_vx[7];
                        end
                        default: ;
                    endcase
                end
                G_SNE_R: if (r_vx != r_vy) n_pc = r_pc + 12'd2;
                G_LDI:   n_i = {4'h0, r_op[11:0]};
                G_JPV0:  n_pc = r_op[11:0] + {4'h0, r_vq};
                G_RND:   n_res = r_op[7:0] & r_rnd;
                G_DRW:   ;
                G_KEY: begin
                    if (r_op[7:0] == KEY_DOWN && key_hit) n_pc = r_pc + 12'd2;
                    else if (r_op[7:0] == KEY_UP && !key_hit) n_pc = r_pc + 12'd2;
                end
                G_MISC: begin
                    case (r_op[7:0])
                        F_GET_DT: n_res = r_delay;
                        F_SET_DT: n_delay = r_vx;
                        F_SET_ST: n_sound = r_vx;
                        F_ADD_I:  n_i = r_i + 16'(r_vx);
                        F_FONT:   n_i = 16'(r_vx) * FONT_STRIDE;
                        default: ;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) r_stack[sp_inc] <= r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i           <= 16'd0;
            r_pc          <= PC_START;
            r_sp          <= '0;
            r_delay       <= 8'd0;
            r_sound       <= 8'd0;
            r_k           <= 4'd0;
            r_opcode_done <= 16'd0;
            r_illegal     <= 1'b0;
            r_changed     <= 1'b0;
            r_pixels      <= 64'd0;
        end else begin
            unique case (i_cmd)
                DP_ACCEPT: begin
                    r_keys        <= i_keys;
                    r_rnd         <= i_random_byte;
                    r_opcode_done <= 16'd0;
                    r_illegal     <= 1'b0;
                    r_changed     <= 1'b0;
                    r_pixels      <= (i_operation == OPER_READ && row_ok) ? row_ext : 64'd0;
                end
                DP_FETCH_LO: r_op[15:8] <= r_mem_q;
                DP_READ_X: begin
                    r_op[7:0] <= r_mem_q;
                    r_pc      <= r_pc + 12'd2;
                end
                DP_READ_Y: r_vx <= r_vq;
                DP_READ_0: r_vy <= r_vq;
                DP_EXEC: begin
                    r_i           <= n_i;
                    r_pc          <= n_pc;
                    r_sp          <= n_sp;
                    r_delay       <= n_delay;
                    r_sound       <= n_sound;
                    r_res         <= n_res;
                    r_flag        <= n_flag;
                    r_k           <= 4'd0;
                    r_hit         <= 1'b0;
                    r_xm          <= r_vx;
                    r_ym          <= r_vy;
                    r_opcode_done <= r_op;
                    r_illegal     <= dec.illegal;
                    r_changed     <= dec.changed;
                end
                DP_BCD, DP_ST_WR, DP_LD_WR: r_k <= r_k + 4'd1;
                DP_DMOD: begin
                    if (r_xm >= 8'(SCREEN_WIDTH)) r_xm <= r_xm - 8'(SCREEN_WIDTH);
                    else if (r_ym >= 8'(SCREEN_HEIGHT)) r_ym <= r_ym - 8'(SCREEN_HEIGHT);
                end
                DP_DR_WR: begin
                    r_k   <= r_k + 4'd1;
                    r_hit <= r_hit | ((scr_rdata & mask) != '0);
                    r_ym  <= (r_ym == 8'(SCREEN_HEIGHT - 1)) ? 8'd0 : r_ym + 8'd1;
                end
                DP_TICK: begin
                    if (r_delay != 8'd0) r_delay <= r_delay - 8'd1;
                    if (r_sound != 8'd0) r_sound <= r_sound - 8'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.k        = r_k;
    assign o_stat.mod_done = (r_xm < 8'(SCREEN_WIDTH)) && (r_ym < 8'(SCREEN_HEIGHT));

    assign o_program_counter = r_pc;
    assign o_opcode_done     = r_opcode_done;
    assign o_bad_opcode      = r_illegal;
    assign o_display_changed = r_changed;
    assign o_sound_on        = r_sound != 8'd0;
    assign o_delay_value     = r_delay;
    assign o_row_pixels      = r_pixels;

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_DR_RD) |-> o_stat.mod_done)
        else $error("sprite row started with unreduced coordinates");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sp) < STACK_DEPTH)
        else $error("stack pointer out of range");

    a_sound_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_TICK && r_sound != 8'd0) |=> (r_sound == $past(r_sound) - 8'd1))
        else $error("sound timer did not tick");

endmodule

/* rtl/c8ic_ctrl.sv */
module c8ic_ctrl
    import c8ic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_operation,
    input  t_dp_stat   i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    t_dec   dec;

    assign dec = decode(i_stat.op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = DP_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = DP_ACCEPT;
                    n_state = (i_operation == OPER_STEP) ? S_FETCH_HI : S_RESP;
                end
            end
            S_FETCH_HI: begin
                o_cmd   = DP_FETCH_HI;
                n_state = S_FETCH_LO;
            end
            S_FETCH_LO: begin
                o_cmd   = DP_FETCH_LO;
                n_state = S_READ_X;
            end
            S_READ_X: begin
                o_cmd   = DP_READ_X;
                n_state = S_READ_Y;
            end
            S_READ_Y: begin
                o_cmd   = DP_READ_Y;
                n_state = S_READ_0;
            end
            S_READ_0: begin
                o_cmd   = DP_READ_0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd = DP_EXEC;
                if (dec.illegal) n_state = S_TICK;
                else begin
                    unique case (dec.kind)
                        K_BCD:   n_state = S_BCD;
                        K_STORE: n_state = S_ST_RD;
                        K_LOAD:  n_state = S_LD_RD;
                        K_DRAW:  n_state = S_DMOD;
                        default: n_state = dec.wr_f ? S_WB_F : (dec.wr_x ? S_WB_X : S_TICK);
                    endcase
                end
            end
            S_WB_F: begin
                o_cmd   = DP_WB_F;
                n_state = dec.wr_x ? S_WB_X : S_TICK;
            end
            S_WB_X: begin
                o_cmd   = DP_WB_X;
                n_state = S_TICK;
            end
            S_BCD: begin
                o_cmd = DP_BCD;
                if (i_stat.k == 4'd2) n_state = S_TICK;
            end
            S_ST_RD: begin
                o_cmd   = DP_ST_RD;
                n_state = S_ST_WR;
            end
            S_ST_WR: begin
                o_cmd   = DP_ST_WR;
                n_state = (i_stat.k == i_stat.op[11:8]) ? S_TICK : S_ST_RD;
            end
            S_LD_RD: begin
                o_cmd   = DP_LD_RD;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd   = DP_LD_WR;
                n_state = (i_stat.k == i_stat.op[11:8]) ? S_TICK : S_LD_RD;
            end
            S_DMOD: begin
                o_cmd = DP_DMOD;
                if (i_stat.mod_done)
                    n_state = (i_stat.op[3:0] == 4'd0) ? S_DR_FLAG : S_DR_RD;
            end
            S_DR_RD: begin
                o_cmd   = DP_DR_RD;
                n_state = S_DR_WR;
            end
            S_DR_WR: begin
                o_cmd   = DP_DR_WR;
                n_state = (i_stat.k == i_stat.op[3:0] - 4'd1) ? S_DR_FLAG : S_DR_RD;
            end
            S_DR_FLAG: begin
                o_cmd   = DP_DR_FLAG;
                n_state = S_TICK;
            end
            S_TICK: begin
                o_cmd   = DP_TICK;
                n_state = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open together");

    a_step_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == OPER_STEP) |=> (r_state == S_FETCH_HI))
        else $error("step did not start a fetch");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && !i_out_ready) |=> (r_state == S_RESP))
        else $error("result dropped while stalled");

endmodule

/* rtl/chip8_instruction_core.sv */
// A write or a row read offers its result in the cycle after its transfer. Beyond fetch,
// execute and timer tick, FX33 writes one digit at a time, FX55/FX65 read and write one
// register at a time, and DXYN reduces its coordinates, updates each sprite row and sets VF.
// Throughput: one item at a time; the next transfer is taken after the result is taken.
// Reset (i_rst_n low, synchronous): PC to 0x200, registers, timers, stack pointer and
// display cleared; program memory and stack contents stay undefined until written.
module chip8_instruction_core
    import c8ic_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int STACK_DEPTH   = DEF_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_mem_address,
    input  logic [7:0]  i_mem_data,
    input  logic [15:0] i_keys,
    input  logic [7:0]  i_random_byte,
    input  logic [4:0]  i_row_select,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_opcode_done,
    output logic        o_bad_opcode,
    output logic        o_display_changed,
    output logic        o_sound_on,
    output logic [7:0]  o_delay_value,
    output logic [63:0] o_row_pixels
);

    // Sequencer and datapath talk only through one command per cycle and a
    // small status bundle (opcode, loop count, coordinate reduction done).
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Controller: hold the result until its transfer, advance through
    // fetch, operand read, execute, loop and timer tick.
    c8ic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Datapath: program memory, register file, display, stack, timers.
    c8ic_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_operation       (i_operation),
        .i_mem_address     (i_mem_address),
        .i_mem_data        (i_mem_data),
        .i_keys            (i_keys),
        .i_random_byte     (i_random_byte),
        .i_row_select      (i_row_select),
        .o_stat            (stat),
        .o_program_counter (o_program_counter),
        .o_opcode_done     (o_opcode_done),
        .o_bad_opcode      (o_bad_opcode),
        .o_display_changed (o_display_changed),
        .o_sound_on        (o_sound_on),
        .o_delay_value     (o_delay_value),
        .o_row_pixels      (o_row_pixels)
    );

endmodule

/* verif/chip8_instruction_core_test.sv */
`timescale 1ns / 100ps

module chip8_instruction_core_test;
    import c8ic_pkg::*;

    typedef struct {
        logic [11:0] pc;
        logic [15:0] opcode;
        logic        illegal;
        logic        changed;
        logic        sound;
        logic [7:0]  delay;
        logic [63:0] pixels;
    } core_result_t;

    // Shadow of the core: memory, display, registers, stack and timers.
    class core_scoreboard;
        logic [7:0]   mem [4096];
        bit           written [4096];
        logic [63:0]  screen [32];
        logic [7:0]   vreg [16];
        logic [15:0]  index_reg;
        logic [11:0]  pc;
        logic [11:0]  stack_mem [32];
        bit           stack_ok [32];
        logic [4:0]   sp;
        logic [7:0]   delay_t;
        logic [7:0]   sound_t;
        core_result_t expected_q [$];
        int           errors;

        function new();
            foreach (mem[i]) begin
                mem[i] = '0;
                written[i] = 0;
            end
            foreach (screen[i]) screen[i] = '0;
            foreach (vreg[i]) vreg[i] = '0;
            foreach (stack_mem[i]) begin
                stack_mem[i] = '0;
                stack_ok[i] = 0;
            end
            index_reg = '0;
            pc = PC_START;
            sp = '0;
            delay_t = '0;
            sound_t = '0;
            errors = 0;
        endfunction

        // Execute one opcode; returns {display changed, illegal}.
        function logic [1:0] execute(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
            logic [3:0]  x;
            logic [7:0]  nn;
            logic [7:0]  vx;
            logic [7:0]  vy;
            logic [8:0]  sum;
            logic [7:0]  bits;
            logic [4:0]  yy;
            logic [5:0]  xx;
            logic [11:0] a;
            logic        hit;
            logic        key_dn;
            logic [1:0]  fl;
            x  = op[11:8];
            nn = op[7:0];
            vx = vreg[x];
            vy = vreg[op[7:4]];
            fl = 2'b00;
            case (op[15:12])
                G_SYS: begin
                    if (nn == OP_CLS) begin
                        foreach (screen[i]) screen[i] = '0;
                        fl[1] = 1'b1;
                    end else if (nn == OP_RET) begin
                        pc = stack_mem[sp];
                        sp = sp - 5'd1;
                    end else begin
                        fl[0] = 1'b1;
                    end
                end
                G_JP: pc = op[11:0];
                G_CALL: begin
                    sp = sp + 5'd1;
                    stack_mem[sp] = pc;
                    stack_ok[sp] = 1;
                    pc = op[11:0];
                end
                G_SE_I:  if (vx == nn) pc = pc + 12'd2;
                G_SNE_I: if (vx != nn) pc = pc + 12'd2;
                G_SE_R:  if (vx == vy) pc = pc + 12'd2;
                G_SNE_R: if (vx != vy) pc = pc + 12'd2;
                G_LD_I:  vreg[x] = nn;
                G_ADD_I: vreg[x] = vx + nn;
                G_ALU: begin
                    // flag goes first, so VX=F keeps the result
                    case (op[3:0])
                        A_MOV: vreg[x] = vy;
                        A_OR:  vreg[x] = vx | vy;
                        A_AND: vreg[x] = vx & vy;
                        A_XOR: vreg[x] = vx ^ vy;
                        A_ADD: begin
                            sum = {1'b0, vx} + {1'b0, vy};
                            vreg[REG_F] = {7'd0, sum[8]};
                            vreg[x] = sum[7:0];
                        end
                        A_SUB: begin
                            vreg[REG_F] = (vx > vy) ? 8'd1 : 8'd0;
                            vreg[x] = vx - vy;
                        end
                        A_SHR: begin
                            vreg[REG_F] = {7'd0, vx[0]};
                            vreg[x] = vx >> 1;
                        end
                        A_SUBN: begin
                            vreg[REG_F] = (vx <= vy) ? 8'd1 : 8'd0;
                            vreg[x] = vy - vx;
                        end
                        A_SHL: begin
                            vreg[REG_F] = {7'd0, vx[7]};
                            vreg[x] = vx << 1;
                        end
                        default: fl[0] = 1'b1;
                    endcase
                end
                G_LDI:  index_reg = {4'd0, op[11:0]};
                G_JPV0: pc = op[11:0] + {4'd0, vreg[0]};
                G_RND:  vreg[x] = nn & rnd;
                G_DRW: begin
                    hit = 1'b0;
                    for (int r = 0; r < op[3:0]; r++) begin
                        a = index_reg[11:0] + 12'(r);
                        bits = mem[a];
                        yy = 5'(vy + r);
                        for (int c = 0; c < 8; c++) begin
                            if (bits[7 - c]) begin
                                xx = 6'(vx + c);
                                if (screen[yy][xx]) hit = 1'b1;
                                screen[yy][xx] = ~screen[yy][xx];
                            end
                        end
                    end
                    vreg[REG_F] = {7'd0, hit};
                    fl[1] = 1'b1;
                end
                G_KEY: begin
                    // keys above 15 never count as pressed
                    key_dn = (vx < 8'd16) ? keys[vx[3:0]] : 1'b0;
                    if (nn == KEY_DOWN) begin
                        if (key_dn) pc = pc + 12'd2;
                    end else if (nn == KEY_UP) begin
                        if (!key_dn) pc = pc + 12'd2;
                    end else begin
                        fl[0] = 1'b1;
                    end
                end
                default: begin
                    case (nn)
                        F_GET_DT: vreg[x] = delay_t;
                        F_SET_DT: delay_t = vx;
                        F_SET_ST: sound_t = vx;
                        F_ADD_I:  index_reg = index_reg + {8'd0, vx};
                        F_FONT:   index_reg = 16'd5 * {8'd0, vx};
                        F_BCD: begin
                            a = index_reg[11:0];
                            mem[a] = 8'(vx / 8'd100);
                            mem[a + 12'd1] = 8'((vx / 8'd10) % 8'd10);
                            mem[a + 12'd2] = 8'(vx % 8'd10);
                            written[a] = 1;
                            written[a + 12'd1] = 1;
                            written[a + 12'd2] = 1;
                        end
                        F_STORE:
                            for (int k = 0; k <= x; k++) begin
                                mem[index_reg[11:0] + 12'(k)] = vreg[k];
                                written[index_reg[11:0] + 12'(k)] = 1;
                            end
                        F_LOAD:
                            for (int k = 0; k <= x; k++) vreg[k] = mem[index_reg[11:0] + 12'(k)];
                        default: fl[0] = 1'b1;
                    endcase
                end
            endcase
            return fl;
        endfunction

        function void note_item(t_oper oper, logic [11:0] addr, logic [7:0] data,
                                logic [15:0] keys, logic [7:0] rnd, logic [4:0] row);
            core_result_t e;
            logic [1:0] fl;
            e.opcode = '0;
            e.illegal = 1'b0;
            e.changed = 1'b0;
            e.pixels = '0;
            case (oper)
                OPER_WRITE: begin
                    mem[addr] = data;
                    written[addr] = 1;
                end
                OPER_STEP: begin
                    e.opcode = {mem[pc], mem[pc + 12'd1]};
                    pc = pc + 12'd2;
                    fl = execute(e.opcode, keys, rnd);
                    e.illegal = fl[0];
                    e.changed = fl[1];
                    if (delay_t != 0) delay_t--;
                    if (sound_t != 0) sound_t--;
                end
                OPER_READ: e.pixels = screen[row];
                default: ;
            endcase
            e.pc = pc;
            e.sound = (sound_t != 0);
            e.delay = delay_t;
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %h, got %h", name, exp_v, got_v);
            end
        endfunction

        function void check_result(core_result_t got);
            core_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result, pc %h", got.pc);
                return;
            end
            e = expected_q.pop_front();
            compare_field("program_counter", e.pc, got.pc);
            compare_field("opcode_done", e.opcode, got.opcode);
            compare_field("bad_opcode", e.illegal, got.illegal);
            compare_field("display_changed", e.changed, got.changed);
            compare_field("sound_on", e.sound, got.sound);
            compare_field("delay_value", e.delay, got.delay);
            compare_field("row_pixels", e.pixels, got.pixels);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = OPER_WRITE;
    logic [11:0] i_mem_address = '0;
    logic [7:0]  i_mem_data = '0;
    logic [15:0] i_keys = '0;
    logic [7:0]  i_random_byte = '0;
    logic [4:0]  i_row_select = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [11:0] o_program_counter;
    logic [15:0] o_opcode_done;
    logic        o_bad_opcode;
    logic        o_display_changed;
    logic        o_sound_on;
    logic [7:0]  o_delay_value;
    logic [63:0] o_row_pixels;

    core_scoreboard sb;
    int out_run_left = 0;
    int issued = 0;

    always #2 i_clk = ~i_clk;

    chip8_instruction_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_mem_address(i_mem_address),
        .i_mem_data(i_mem_data), .i_keys(i_keys),
        .i_random_byte(i_random_byte), .i_row_select(i_row_select),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_program_counter(o_program_counter), .o_opcode_done(o_opcode_done),
        .o_bad_opcode(o_bad_opcode), .o_display_changed(o_display_changed),
        .o_sound_on(o_sound_on), .o_delay_value(o_delay_value),
        .o_row_pixels(o_row_pixels)
    );

    // Mostly short idles, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Check each result transfer, then pick the next stretch of ready or stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_program_counter, o_opcode_done, o_bad_opcode,
                              o_display_changed, o_sound_on, o_delay_value, o_row_pixels});
        if (out_run_left > 0) begin
            out_run_left--;
        end else if ($urandom_range(0, 1)) begin
            i_out_ready <= 1'b1;
            out_run_left = $urandom_range(0, 40);
        end else begin
            i_out_ready <= 1'b0;
            out_run_left = pick_gap();
        end
    end

    // Hold valid and payload until the transfer; lower valid only ahead of a gap.
    task automatic send_item(t_oper oper, logic [11:0] addr, logic [7:0] data,
                             logic [15:0] keys, logic [7:0] rnd, logic [4:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= oper;
        i_mem_address <= addr;
        i_mem_data    <= data;
        i_keys        <= keys;
        i_random_byte <= rnd;
        i_row_select  <= row;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        sb.note_item(oper, addr, data, keys, rnd, row);
        issued++;
    endtask

    task automatic send_simple(t_oper oper, logic [11:0] addr, logic [7:0] data,
                               logic [4:0] row);
        send_item(oper, addr, data, 16'($urandom), 8'($urandom), row);
    endtask

    // Plant the opcode at the current PC, fill any byte it reads that was
    // never written, then execute it.
    task automatic run_opcode(logic [15:0] op);
        logic [11:0] at;
        logic [11:0] ra;
        int          reads;
        // never return through a stack slot that no call has filled
        if (op[15:12] == G_SYS && op[7:0] == OP_RET && !sb.stack_ok[sb.sp])
            op = {G_CALL, op[11:0]};
        at = sb.pc;
        send_simple(OPER_WRITE, at, op[15:8], 5'($urandom));
        send_simple(OPER_WRITE, at + 12'd1, op[7:0], 5'($urandom));
        reads = 0;
        if (op[15:12] == G_DRW)
            reads = int'(op[3:0]);
        else if (op[15:12] == G_MISC && op[7:0] == F_LOAD)
            reads = int'(op[11:8]) + 1;
        for (int k = 0; k < reads; k++) begin
            ra = sb.index_reg[11:0] + 12'(k);
            if (!sb.written[ra])
                send_simple(OPER_WRITE, ra, 8'($urandom), 5'($urandom));
        end
        send_item(OPER_STEP, 12'($urandom), 8'($urandom), 16'($urandom),
                  8'($urandom), 5'($urandom));
    endtask

    function automatic logic [15:0] pick_opcode();
        logic [3:0]  g;
        logic [15:0] op;
        logic [7:0]  f_codes [8];
        f_codes = '{F_GET_DT, F_SET_DT, F_SET_ST, F_ADD_I, F_FONT, F_BCD, F_STORE, F_LOAD};
        g  = 4'($urandom);
        op = {g, 12'($urandom)};
        case (g)
            G_SYS: case ($urandom_range(0, 3))
                0: op[7:0] = OP_CLS;
                1, 2: op[7:0] = OP_RET;
                default: ;
            endcase
            G_LD_I: if ($urandom_range(0, 1)) op[7:0] = 8'($urandom_range(0, 20));
            G_DRW: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 5));
            G_KEY: case ($urandom_range(0, 4))
                0, 1: op[7:0] = KEY_DOWN;
                2, 3: op[7:0] = KEY_UP;
                default: ;
            endcase
            G_MISC: if ($urandom_range(0, 7) != 0) op[7:0] = f_codes[$urandom_range(0, 7)];
            default: ;
        endcase
        return op;
    endfunction

    initial begin
        int pick;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clear, illegal 0NNN, flag-as-operand add, wrapped draw,
        // FX0A, key index above 15, full dump, call/return.
        run_opcode(16'h00E0);
        run_opcode(16'h0123);
        run_opcode(16'h6AFF);
        run_opcode(16'h8FA4);
        run_opcode(16'hDAAF);
        run_opcode(16'hDAA0);
        run_opcode(16'hF10A);
        run_opcode(16'hEA9E);
        run_opcode(16'hFF55);
        run_opcode(16'h2ABC);
        run_opcode(16'h00EE);
        send_simple(OPER_READ, '0, '0, 5'd0);
        send_simple(OPER_READ, '0, '0, 5'd31);
        send_simple(OPER_NONE, '0, '0, '0);

        // Random: mostly instruction steps with random content.
        issued = 0;
        while (issued < 700) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) run_opcode(pick_opcode());
            else if (pick < 88) send_simple(OPER_READ, '0, '0, 5'($urandom));
            else if (pick < 96) send_simple(OPER_WRITE, 12'($urandom), 8'($urandom), '0);
            else send_simple(OPER_NONE, 12'($urandom), 8'($urandom), 5'($urandom));
        end
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
